// ===== sv/ocf_pkg.sv =====
// ocf_pkg: shared types, constants and helpers of the orbit course follower
// no dependencies

package ocf_pkg;

	localparam int DEF_CORDIC_STEPS  = 24;
	localparam int DEF_FRACTION_BITS = 16;

	// datapath widths
	localparam int DW  = 58;	// cordic x/y
	localparam int ZW  = 35;	// angle, q30
	localparam int MAW = 36;	// multiplier operand a
	localparam int MBW = 32;	// multiplier operand b
	localparam int PW  = 68;	// product and wide sums

	localparam logic [29:0]          INV_GAIN_Q30 = 30'd652032874;
	localparam logic signed [ZW-1:0] PI_Q30       = 35'sd3373259426;
	localparam logic signed [ZW-1:0] HALF_PI_Q30  = 35'sd1686629713;

	localparam logic [2:0] REG_CENTER_NORTH  = 3'd0;
	localparam logic [2:0] REG_CENTER_EAST   = 3'd1;
	localparam logic [2:0] REG_ORBIT_RADIUS  = 3'd2;
	localparam logic [2:0] REG_TURN_CW       = 3'd3;
	localparam logic [2:0] REG_RADIAL_GAIN   = 3'd4;
	localparam logic [2:0] REG_INTEGRAL_GAIN = 3'd5;
	localparam logic [2:0] REG_TIME_STEP     = 3'd6;

	typedef enum logic [3:0] {
		S_IDLE, S_VEC1, S_ROT1, S_MHI, S_MLO, S_DIST, S_MTS, S_INTG,
		S_ARG, S_ROT2, S_MIG, S_CMD
	} state_t;

	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		case (i)
			5'd0: atan_q30 = 30'd843314857;
			5'd1: atan_q30 = 30'd497837829;
			5'd2: atan_q30 = 30'd263043837;
			5'd3: atan_q30 = 30'd133525159;
			5'd4: atan_q30 = 30'd67021687;
			5'd5: atan_q30 = 30'd33543516;
			5'd6: atan_q30 = 30'd16775851;
			5'd7: atan_q30 = 30'd8388437;
			5'd8: atan_q30 = 30'd4194283;
			5'd9: atan_q30 = 30'd2097149;
			5'd31: atan_q30 = 30'd0;
			default: atan_q30 = 30'd1 << (5'd30 - i);
		endcase
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
		if (v > PW'(64'sh7FFFFFFF))
			sat32 = 32'sh7FFFFFFF;
		else if (v < -PW'(64'sh80000000))
			sat32 = 32'sh80000000;
		else
			sat32 = v[31:0];
	endfunction

	// round half up, then arithmetic shift right
	function automatic logic signed [PW-1:0] rshift(input logic signed [PW-1:0] v,
			input int s);
		rshift = (v + (PW'(1) <<< (s - 1))) >>> s;
	endfunction

endpackage

// ===== sv/ocf_mul.sv =====
// ocf_mul: shared signed multiplier with registered product
// depends on ocf_pkg

module ocf_mul import ocf_pkg::*; (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [MAW-1:0] a,
	input  logic signed [MBW-1:0] b,
	output logic signed [PW-1:0]  p
);

	logic signed [PW-1:0] p_q;

	always_ff @(posedge clk) begin
		if (en)
			p_q <= PW'(a) * PW'(b);
	end

	assign p = p_q;

endmodule

// ===== sv/ocf_cordic.sv =====
// ocf_cordic: iterative vectoring cordic, one micro-rotation per cycle
// depends on ocf_pkg

module ocf_cordic import ocf_pkg::*; #(
	parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [DW-1:0] x0,
	input  logic signed [DW-1:0] y0,
	output logic                 done,
	output logic signed [DW-1:0] x,
	output logic signed [ZW-1:0] z
);

	localparam int IW = $clog2(CORDIC_STEPS);

	logic signed [DW-1:0] x_q, y_q, dx, dy;
	logic signed [ZW-1:0] z_q, a;
	logic [IW-1:0]        i_q;
	logic                 busy_q, done_q;

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign a  = ZW'(atan_q30(5'(i_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == IW'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= '0;
		end else if (busy_q) begin
			if (!y_q[DW-1]) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + a;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - a;
			end
		end
	end

	assign done = done_q;
	assign x    = x_q;
	assign z    = z_q;

endmodule

// ===== sv/orbit_course_follower.sv =====
// orbit_course_follower: top level, sequencer, configuration and datapath
// depends on ocf_pkg, ocf_cordic, ocf_mul
//
// use: write the orbit registers on the cfg port (cfg_write, cfg_index,
// cfg_data) while idle. feed vehicle positions on the input channel
// (in_valid / in_stall); each item gives one course_command item on the
// output channel (out_valid / out_stall).
// each item passes twice through the single shared cordic unit, with five
// products on one shared multiplier: four between the passes, one after.
// a position on the orbit centre skips the first cordic pass and both
// magnitude products. in_stall is high while an item is being worked on,
// so a new position is accepted only once the sequencer is back in idle.
// the result sits in an output register; a new item may be accepted while it
// waits. if the receiver still stalls when the next result is ready, the
// sequencer holds in its final state until the register frees.
// reset clears the error integral, the registers (turn_clockwise to 1) and
// the handshake state; the block is ready in the first cycle after reset.

module orbit_course_follower import ocf_pkg::*; #(
	parameter int CORDIC_STEPS  = DEF_CORDIC_STEPS,
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] position_north,
	input  logic signed [31:0] position_east,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] course_command
);

	localparam int QD = 30 - FRACTION_BITS;

	// configuration registers
	logic signed [31:0] center_north_q, center_east_q;
	logic [30:0]        orbit_radius_q, radial_gain_q, integral_gain_q, time_step_q;
	logic               turn_cw_q;

	// item state
	state_t               state_q, state_d;
	logic signed [32:0]   dn_q, de_q;
	logic                 zero_q;
	logic signed [ZW-1:0] z0_q, phi_q;
	logic signed [PW-1:0] acc_q;
	logic signed [31:0]   err_q, integ_q;
	logic                 out_valid_q;
	logic signed [31:0]   out_q;

	// shared units
	logic                  mul_en;
	logic signed [MAW-1:0] mul_a;
	logic signed [MBW-1:0] mul_b;
	logic signed [PW-1:0]  mul_p;
	logic                  c_start, c_done;
	logic signed [DW-1:0]  c_x0, c_y0, c_x;
	logic signed [ZW-1:0]  c_z;

	// datapath arithmetic
	logic signed [DW-1:0] vx, vy;
	logic signed [PW-1:0] radial_dist, integ_sum, arg, arg_lim, corr, phi_r, cmd;
	logic                 accept, out_free;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	ocf_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	ocf_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (c_start),
		.x0     (c_x0),
		.y0     (c_y0),
		.done   (c_done),
		.x      (c_x),
		.z      (c_z)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_north_q  <= '0;
			center_east_q   <= '0;
			orbit_radius_q  <= '0;
			turn_cw_q       <= 1'b1;
			radial_gain_q   <= '0;
			integral_gain_q <= '0;
			time_step_q     <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_CENTER_NORTH:  center_north_q  <= cfg_data;
				REG_CENTER_EAST:   center_east_q   <= cfg_data;
				REG_ORBIT_RADIUS:  orbit_radius_q  <= cfg_data[30:0];
				REG_TURN_CW:       turn_cw_q       <= cfg_data[0];
				REG_RADIAL_GAIN:   radial_gain_q   <= cfg_data[30:0];
				REG_INTEGRAL_GAIN: integral_gain_q <= cfg_data[30:0];
				REG_TIME_STEP:     time_step_q     <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (accept) state_d = S_VEC1;
			S_VEC1: state_d = zero_q ? S_DIST : S_ROT1;
			S_ROT1: if (c_done) state_d = S_MHI;
			S_MHI:  state_d = S_MLO;
			S_MLO:  state_d = S_DIST;
			S_DIST: state_d = S_MTS;
			S_MTS:  state_d = S_INTG;
			S_INTG: state_d = S_ARG;
			S_ARG:  state_d = S_ROT2;
			S_ROT2: if (c_done) state_d = S_MIG;
			S_MIG:  state_d = S_CMD;
			S_CMD:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// first cordic operands: offset scaled by 2^16, folded into the right half plane
	assign vx = DW'(dn_q) <<< 16;
	assign vy = DW'(de_q) <<< 16;

	// atan argument, clamped before it goes to the cordic
	assign arg_lim = PW'(1) <<< (FRACTION_BITS + 24);
	always_comb begin
		arg = rshift(mul_p, FRACTION_BITS);
		if (arg > arg_lim)
			arg = arg_lim;
		if (arg < -arg_lim)
			arg = -arg_lim;
	end

	// sequencer outputs: shared unit control
	always_comb begin
		mul_en  = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		c_start = 1'b0;
		c_x0    = '0;
		c_y0    = '0;
		case (state_q)
			S_VEC1: begin
				c_start = !zero_q;
				c_x0    = dn_q[32] ? -vx : vx;
				c_y0    = dn_q[32] ? -vy : vy;
			end
			S_MHI: begin
				mul_en = 1'b1;
				mul_a  = MAW'(c_x >>> 16);
				mul_b  = MBW'(INV_GAIN_Q30);
			end
			S_MLO: begin
				mul_en = 1'b1;
				mul_a  = MAW'(c_x[15:0]);
				mul_b  = MBW'(INV_GAIN_Q30);
			end
			S_MTS: begin
				mul_en = 1'b1;
				mul_a  = MAW'(err_q);
				mul_b  = MBW'(time_step_q);
			end
			S_INTG: begin
				mul_en = 1'b1;
				mul_a  = MAW'(err_q);
				mul_b  = MBW'(radial_gain_q);
			end
			S_ARG: begin
				c_start = 1'b1;
				c_x0    = DW'(1) <<< 30;
				c_y0    = DW'(arg <<< QD);
			end
			S_MIG: begin
				mul_en = 1'b1;
				mul_a  = MAW'(integ_q);
				mul_b  = MBW'(integral_gain_q);
			end
			default: ;
		endcase
	end

	// distance from the two partial products of K*|v| times 1/K
	assign radial_dist = zero_q ? '0 :
		(acc_q + (mul_p >>> 16) + (PW'(1) <<< 29)) >>> 30;
	assign integ_sum = PW'(integ_q) + rshift(mul_p, FRACTION_BITS);

	// course = phi +/- (pi/2 + atan + integral term)
	assign corr  = rshift(PW'(HALF_PI_Q30), QD) + rshift(PW'(c_z), QD)
		+ rshift(mul_p, FRACTION_BITS);
	assign phi_r = rshift(PW'(phi_q), QD);
	assign cmd   = turn_cw_q ? phi_r + corr : phi_r - corr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			integ_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_INTG)
				integ_q <= sat32(integ_sum);
			if (state_q == S_CMD && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					dn_q   <= 33'(position_north) - 33'(center_north_q);
					de_q   <= 33'(position_east) - 33'(center_east_q);
					zero_q <= (position_north == center_north_q)
						&& (position_east == center_east_q);
				end
			end
			S_VEC1: begin
				phi_q <= '0;
				if (dn_q[32])
					z0_q <= de_q[32] ? -PI_Q30 : PI_Q30;
				else
					z0_q <= '0;
			end
			S_ROT1: if (c_done) phi_q <= z0_q + c_z;
			S_MLO:  acc_q <= mul_p;
			S_DIST: err_q <= sat32(radial_dist - PW'(orbit_radius_q));
			S_CMD:  if (out_free) out_q <= sat32(cmd);
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign course_command = out_q;

	// an accepted item always starts the sequencer
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_VEC1)
		else $error("accepted item did not start the sequencer");

	// the cordic only finishes while the sequencer waits on it
	a_cordic_done: assert property (@(posedge clk) disable iff (!arst_n)
		c_done |-> (state_q == S_ROT1 || state_q == S_ROT2))
		else $error("cordic finished outside a rotation state");

	// leaving the final state always presents a result
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMD && out_free) |=> out_valid_q && state_q == S_IDLE)
		else $error("result not presented");

endmodule
